### sv/mtsp_pkg.sv
package mtsp_pkg;

   localparam int SAMPLE_W = 12;
   localparam int ANGLE_W  = 13;
   localparam int POS_W    = 21;
   localparam int TURNS_W  = 8;
   localparam int GAIN_W   = 16;
   localparam int LEVEL_W  = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;

   // one full turn in 1/16 degree
   localparam int TURN_UNITS = 5760;
   localparam int WRAP_LOW   = 800;
   localparam int WRAP_HIGH  = 4800;
   localparam int SUM_LIMIT  = 16000;
   localparam int OUT_LIMIT  = 1440;
   localparam int POS_MAX    = 1048575;
   localparam int POS_MIN    = -1048576;
   localparam int TURNS_MAX  = 127;
   localparam int TURNS_MIN  = -128;

   // adc*5760/4095 = (adc*128)/91, done as (adc*RECIP) >> SHIFT, exact for 12-bit adc
   localparam int FRESH_RECIP = 737461;
   localparam int FRESH_PROD_W = 32;
   localparam int FRESH_SHIFT = 19;

   // level = (720 + a)*25/288; /288 = (>>5) then /9 as (z*RECIP) >> SHIFT
   localparam int LEVEL_OFFSET = 720;
   localparam int LEVEL_SCALE  = 25;
   localparam int LEVEL_NUM_W  = 18;
   localparam int LEVEL_PRE_SHIFT = 5;
   localparam int LEVEL_RECIP  = 14564;
   localparam int LEVEL_PROD_W = 27;
   localparam int LEVEL_SHIFT  = 17;
   localparam int LEVEL_MAX    = 562;

   localparam int ERR_W   = 22;
   localparam int SUM_W   = 15;
   localparam int DERIV_W = 23;
   localparam int ACC_W   = 42;
   localparam int DRIVE_W = 12;
   localparam int CMD_W   = 14;
   localparam int ACC_SHIFT = 8;

   localparam int STAGES = 9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET = 3'd0,
      CSR_GAIN_P = 3'd1,
      CSR_GAIN_I = 3'd2,
      CSR_GAIN_D = 3'd3,
      CSR_RUN    = 3'd4
   } csr_index_type;

endpackage

### sv/multiturn_servo_pid_with_median_top.sv
// Servo position loop with median-filtered potentiometer input.
// Each accepted request passes through one pipeline register per stage on its way to rsp_valid.
// Throughput: one request per cycle; stages hold and collapse bubbles under back-pressure.
// Loop state (turn count, angle, error sum, previous error) updates in stages 4 and 5.
// Reset (synchronous): clears the sample window, loop state, configuration registers and valid bits.
// There is no clearing pass; the block takes requests in the cycle after reset.
module multiturn_servo_pid_with_median_top
   import mtsp_pkg::*;
#(
   parameter int WINDOW_DEPTH = 5,
   parameter int TURN_BITS    = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SAMPLE_W-1:0]        req_adc_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [LEVEL_W-1:0]         rsp_pwm_level,
   output logic signed [POS_W-1:0]    rsp_position,
   output logic signed [TURNS_W-1:0]  rsp_turns,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int PW = (TURN_BITS + 14 > 22) ? TURN_BITS + 14 : 22;
   localparam int TX = TURN_BITS + 8;
   localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
   localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
   localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
   localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
   localparam int PROD_D_W = GAIN_W + 1 + DERIV_W;

   // configuration
   logic signed [POS_W-1:0]  target_ff;
   logic [GAIN_W-1:0]        gain_p_ff, gain_i_ff, gain_d_ff;
   logic                     run_enable_ff;

   // loop state
   logic [SAMPLE_W-1:0]         window_ff [WINDOW_DEPTH];
   logic [ANGLE_W-1:0]          angle_ff;
   logic signed [TURN_BITS-1:0] turn_ff;
   logic signed [SUM_W-1:0]     sum_ff;
   logic signed [ERR_W-1:0]     prev_err_ff;

   // pipeline control
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES:0]   take;

   // pipeline payload
   logic                      run_a_ff, run_b_ff, run_c_ff, run_d_ff, run_e_ff;
   logic                      run_f_ff, run_g_ff, run_h_ff;
   logic [SAMPLE_W-1:0]       median_ff;
   logic [ANGLE_W-1:0]        fresh_ff;
   logic signed [POS_W-1:0]   pos_e_ff, pos_f_ff, pos_g_ff, pos_h_ff;
   logic signed [TURNS_W-1:0] turns_e_ff, turns_f_ff, turns_g_ff, turns_h_ff;
   logic signed [ERR_W-1:0]   err_e_ff;
   logic signed [DERIV_W-1:0] deriv_e_ff;
   logic [ANGLE_W-1:0]        angle_e_ff, angle_f_ff, angle_g_ff;
   logic signed [PROD_P_W-1:0] prod_p_ff;
   logic signed [PROD_I_W-1:0] prod_i_ff;
   logic signed [PROD_D_W-1:0] prod_d_ff;
   logic signed [DRIVE_W-1:0] drive_g_ff;
   logic [LEVEL_NUM_W-1:0]    num_h_ff;
   logic [LEVEL_W-1:0]        level_ff;
   logic signed [POS_W-1:0]   position_ff;
   logic signed [TURNS_W-1:0] turns_ff;

   // combinational
   logic [SAMPLE_W-1:0]         median_in;
   logic [FRESH_PROD_W-1:0]     fresh_prod;
   logic [ANGLE_W-1:0]          fresh_in;
   logic signed [TURN_BITS-1:0] turn_in;
   logic signed [PW-1:0]        pos_wide;
   logic signed [POS_W-1:0]     pos_in;
   logic signed [TX-1:0]        turn_x;
   logic signed [TURNS_W-1:0]   turns_in;
   logic signed [ERR_W-1:0]     err_in;
   logic signed [DERIV_W-1:0]   sum_wide;
   logic signed [SUM_W-1:0]     sum_in;
   logic signed [DERIV_W-1:0]   deriv_in;
   logic signed [ACC_W-1:0]     acc;
   logic signed [ACC_W-ACC_SHIFT-1:0] acc_shr;
   logic signed [DRIVE_W-1:0]   drive_in;
   logic signed [CMD_W-1:0]     cmd;
   logic [ANGLE_W-1:0]          cmd_wrap;
   logic [LEVEL_NUM_W-1:0]      num_in;
   logic [LEVEL_PROD_W-1:0]     level_prod;
   logic [LEVEL_W-1:0]          level_in;

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         run_enable_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET: target_ff     <= csr_wdata;
            CSR_GAIN_P: gain_p_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I: gain_i_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D: gain_d_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_RUN:    run_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- handshake and stage advance ----------------
   always_comb begin
      take[STAGES] = rsp_ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         take[k] = valid_ff[k-1] && (!valid_ff[k] || take[k+1]);
      end
      req_ready = !valid_ff[0] || take[1];
      take[0]   = req_valid && req_ready;
      for (int k = 0; k < STAGES; k++) begin
         valid_in[k] = take[k] || (valid_ff[k] && !take[k+1]);
      end
   end

   assign rsp_valid = valid_ff[STAGES-1];

   // ---------------- datapath ----------------
   mtsp_median #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_median (
      .window_i(window_ff),
      .median_o(median_in)
   );

   always_comb begin
      fresh_prod = FRESH_PROD_W'(median_ff) * FRESH_PROD_W'(FRESH_RECIP);
      fresh_in   = fresh_prod[FRESH_PROD_W-1:FRESH_SHIFT];

      // count a turn when the angle wraps between the low and high zones
      turn_in = turn_ff;
      if (fresh_ff < ANGLE_W'(WRAP_LOW) && angle_ff > ANGLE_W'(WRAP_HIGH)) begin
         if (turn_ff != TURN_MAX) turn_in = turn_ff + TURN_BITS'(1);
      end else if (fresh_ff > ANGLE_W'(WRAP_HIGH) && angle_ff < ANGLE_W'(WRAP_LOW)) begin
         if (turn_ff != TURN_MIN) turn_in = turn_ff - TURN_BITS'(1);
      end
   end

   always_comb begin
      pos_wide = PW'(turn_ff) * PW'(TURN_UNITS) + $signed(PW'(angle_ff));
      if (pos_wide > PW'(POS_MAX)) begin
         pos_in = POS_W'(POS_MAX);
      end else if (pos_wide < PW'(POS_MIN)) begin
         pos_in = POS_W'(POS_MIN);
      end else begin
         pos_in = POS_W'(pos_wide);
      end

      turn_x = TX'(turn_ff);
      if (turn_x > TX'(TURNS_MAX)) begin
         turns_in = TURNS_W'(TURNS_MAX);
      end else if (turn_x < TX'(TURNS_MIN)) begin
         turns_in = TURNS_W'(TURNS_MIN);
      end else begin
         turns_in = TURNS_W'(turn_x);
      end

      err_in   = ERR_W'(target_ff) - ERR_W'(pos_in);
      sum_wide = DERIV_W'(sum_ff) + DERIV_W'(err_in);
      if (sum_wide > DERIV_W'(SUM_LIMIT)) begin
         sum_in = SUM_W'(SUM_LIMIT);
      end else if (sum_wide < DERIV_W'(-SUM_LIMIT)) begin
         sum_in = SUM_W'(-SUM_LIMIT);
      end else begin
         sum_in = SUM_W'(sum_wide);
      end
      deriv_in = DERIV_W'(err_in) - DERIV_W'(prev_err_ff);
   end

   always_comb begin
      acc     = ACC_W'(prod_p_ff) + ACC_W'(prod_i_ff) + ACC_W'(prod_d_ff);
      // arithmetic shift floors toward minus infinity
      acc_shr = acc[ACC_W-1:ACC_SHIFT];
      if (acc_shr > (ACC_W-ACC_SHIFT)'(OUT_LIMIT)) begin
         drive_in = DRIVE_W'(OUT_LIMIT);
      end else if (acc_shr < (ACC_W-ACC_SHIFT)'(-OUT_LIMIT)) begin
         drive_in = DRIVE_W'(-OUT_LIMIT);
      end else begin
         drive_in = DRIVE_W'(acc_shr);
      end
   end

   always_comb begin
      cmd = CMD_W'(drive_g_ff) + $signed(CMD_W'(angle_g_ff));
      // reduce into one turn; the command stays within one turn of the range
      if (cmd < 0) begin
         cmd_wrap = ANGLE_W'(cmd + CMD_W'(TURN_UNITS));
      end else if (cmd >= CMD_W'(TURN_UNITS)) begin
         cmd_wrap = ANGLE_W'(cmd - CMD_W'(TURN_UNITS));
      end else begin
         cmd_wrap = ANGLE_W'(cmd);
      end
      num_in = (LEVEL_NUM_W'(cmd_wrap) + LEVEL_NUM_W'(LEVEL_OFFSET))
               * LEVEL_NUM_W'(LEVEL_SCALE);

      level_prod = LEVEL_PROD_W'(num_h_ff[LEVEL_NUM_W-1:LEVEL_PRE_SHIFT])
                   * LEVEL_PROD_W'(LEVEL_RECIP);
      level_in   = level_prod[LEVEL_PROD_W-1:LEVEL_SHIFT];
   end

   // ---------------- control and loop state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         angle_ff    <= '0;
         turn_ff     <= '0;
         sum_ff      <= '0;
         prev_err_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         // shift the window on each accepted request while running
         if (take[0] && run_enable_ff) begin
            for (int i = 0; i + 1 < WINDOW_DEPTH; i++) begin
               window_ff[i] <= window_ff[i+1];
            end
            window_ff[WINDOW_DEPTH-1] <= req_adc_sample;
         end
         if (take[3] && run_c_ff) begin
            turn_ff  <= turn_in;
            angle_ff <= fresh_ff;
         end
         if (take[4] && run_d_ff) begin
            sum_ff      <= sum_in;
            prev_err_ff <= err_in;
         end
      end
   end

   // ---------------- pipeline payload ----------------
   always_ff @(posedge clock) begin
      if (take[0]) begin
         run_a_ff <= run_enable_ff;
      end
      if (take[1]) begin
         median_ff <= median_in;
         run_b_ff  <= run_a_ff;
      end
      if (take[2]) begin
         fresh_ff <= fresh_in;
         run_c_ff <= run_b_ff;
      end
      if (take[3]) begin
         run_d_ff <= run_c_ff;
      end
      if (take[4]) begin
         pos_e_ff   <= pos_in;
         turns_e_ff <= turns_in;
         err_e_ff   <= err_in;
         deriv_e_ff <= deriv_in;
         angle_e_ff <= angle_ff;
         run_e_ff   <= run_d_ff;
      end
      if (take[5]) begin
         prod_p_ff  <= PROD_P_W'($signed({1'b0, gain_p_ff})) * PROD_P_W'(err_e_ff);
         prod_i_ff  <= PROD_I_W'($signed({1'b0, gain_i_ff})) * PROD_I_W'(sum_ff);
         prod_d_ff  <= PROD_D_W'($signed({1'b0, gain_d_ff})) * PROD_D_W'(deriv_e_ff);
         angle_f_ff <= angle_e_ff;
         pos_f_ff   <= pos_e_ff;
         turns_f_ff <= turns_e_ff;
         run_f_ff   <= run_e_ff;
      end
      if (take[6]) begin
         drive_g_ff <= drive_in;
         angle_g_ff <= angle_f_ff;
         pos_g_ff   <= pos_f_ff;
         turns_g_ff <= turns_f_ff;
         run_g_ff   <= run_f_ff;
      end
      if (take[7]) begin
         num_h_ff   <= num_in;
         pos_h_ff   <= pos_g_ff;
         turns_h_ff <= turns_g_ff;
         run_h_ff   <= run_g_ff;
      end
      if (take[8]) begin
         // drive zero while the loop is halted
         level_ff    <= run_h_ff ? level_in : '0;
         position_ff <= pos_h_ff;
         turns_ff    <= turns_h_ff;
      end
   end

   assign rsp_pwm_level = level_ff;
   assign rsp_position  = position_ff;
   assign rsp_turns     = turns_ff;

   // ---------------- assertions ----------------
   a_sum_bounded: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= SUM_W'(SUM_LIMIT) && sum_ff >= SUM_W'(-SUM_LIMIT))
      else $error("error sum left its clamp range");

   a_angle_bounded: assert property (@(posedge clock) disable iff (reset)
      angle_ff <= ANGLE_W'(TURN_UNITS))
      else $error("filtered angle beyond one turn");

   a_halt_holds_turns: assert property (@(posedge clock) disable iff (reset)
      take[3] && !run_c_ff |=> $stable(turn_ff) && $stable(angle_ff))
      else $error("turn state changed on a halted request");

   a_halt_holds_sum: assert property (@(posedge clock) disable iff (reset)
      take[4] && !run_d_ff |=> $stable(sum_ff) && $stable(prev_err_ff))
      else $error("error state changed on a halted request");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pwm_level <= LEVEL_W'(LEVEL_MAX))
      else $error("pwm level out of range");

endmodule

### sv/mtsp_median.sv
module mtsp_median
   import mtsp_pkg::*;
#(
   parameter int WINDOW_DEPTH = 5
) (
   input  logic [SAMPLE_W-1:0] window_i [WINDOW_DEPTH],
   output logic [SAMPLE_W-1:0] median_o
);

   logic [SAMPLE_W-1:0] sort_v [WINDOW_DEPTH];
   logic [SAMPLE_W-1:0] swap_v;

   // odd-even transposition network: WINDOW_DEPTH passes sort the window
   always_comb begin
      swap_v = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         sort_v[i] = window_i[i];
      end
      for (int p = 0; p < WINDOW_DEPTH; p++) begin
         for (int i = p % 2; i + 1 < WINDOW_DEPTH; i += 2) begin
            if (sort_v[i] > sort_v[i+1]) begin
               swap_v      = sort_v[i];
               sort_v[i]   = sort_v[i+1];
               sort_v[i+1] = swap_v;
            end
         end
      end
   end

   assign median_o = sort_v[WINDOW_DEPTH/2];

endmodule

### test/servo_loop_checker.sv
module servo_loop_checker
   import mtsp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [SAMPLE_W-1:0]        req_adc_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [LEVEL_W-1:0]         rsp_pwm_level,
   input  logic signed [POS_W-1:0]    rsp_position,
   input  logic signed [TURNS_W-1:0]  rsp_turns,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   output int                         mismatches,
   output int                         readings_due,
   output int                         readings_checked,
   output int                         turns_high,
   output int                         turns_low
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     WINDOW_DEPTH = 5;
   localparam longint ADC_SPAN     = 4095;
   // level = (500 us + angle * 2000/2880) * 125 / 1000, kept in integer form
   localparam longint PWM_BASE  = 1440000;
   localparam longint PWM_STEP  = 2000;
   localparam longint PWM_SCALE = 125;
   localparam longint PWM_DIV   = 2880000;

   typedef struct {
      logic [LEVEL_W-1:0]        level;
      logic signed [POS_W-1:0]   position;
      logic signed [TURNS_W-1:0] turns;
   } servo_reading_type;

   // mirrored registers
   logic signed [POS_W-1:0] target;
   logic [GAIN_W-1:0]       kp, ki, kd;
   logic                    running;

   // mirrored loop state
   logic [SAMPLE_W-1:0]       window [WINDOW_DEPTH];
   logic [ANGLE_W-1:0]        angle;
   logic signed [TURNS_W-1:0] turn_count;
   logic signed [SUM_W-1:0]   error_sum;
   logic signed [ERR_W-1:0]   last_error;

   servo_reading_type readings_q [$];

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [SAMPLE_W-1:0] window_median();
      logic [SAMPLE_W-1:0] v [WINDOW_DEPTH];
      logic [SAMPLE_W-1:0] k;
      int j;
      v = window;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
         k = v[i];
         j = i - 1;
         while (j >= 0 && v[j] > k) begin
            v[j + 1] = v[j];
            j--;
         end
         v[j + 1] = k;
      end
      return v[WINDOW_DEPTH / 2];
   endfunction

   task automatic servo_step(input logic [SAMPLE_W-1:0] sample,
                             output servo_reading_type r);
      longint fresh, turns_now, pos, err, sum, acc, drive, cmd;
      turns_now = turn_count;
      r.level = '0;
      if (running) begin
         for (int i = 0; i + 1 < WINDOW_DEPTH; i++)
            window[i] = window[i + 1];
         window[WINDOW_DEPTH - 1] = sample;
         fresh = longint'(window_median()) * TURN_UNITS / ADC_SPAN;

         // wrap across the pot's dead band counts a turn
         if (fresh < WRAP_LOW && longint'(angle) > WRAP_HIGH)
            turns_now = clip(turns_now + 1, TURNS_MIN, TURNS_MAX);
         else if (fresh > WRAP_HIGH && longint'(angle) < WRAP_LOW)
            turns_now = clip(turns_now - 1, TURNS_MIN, TURNS_MAX);
         angle = ANGLE_W'(fresh);
         turn_count = TURNS_W'(turns_now);

         pos = clip(turns_now * TURN_UNITS + fresh, POS_MIN, POS_MAX);
         err = longint'(target) - pos;
         sum = clip(longint'(error_sum) + err, -SUM_LIMIT, SUM_LIMIT);
         error_sum = SUM_W'(sum);
         acc = longint'(kp) * err + longint'(ki) * sum
               + longint'(kd) * (err - longint'(last_error));
         last_error = ERR_W'(err);
         drive = clip(acc >>> ACC_SHIFT, -OUT_LIMIT, OUT_LIMIT);

         cmd = (fresh + drive) % TURN_UNITS;
         if (cmd < 0)
            cmd += TURN_UNITS;
         r.level = LEVEL_W'((PWM_BASE + PWM_STEP * cmd) * PWM_SCALE / PWM_DIV);
      end else begin
         pos = clip(turns_now * TURN_UNITS + longint'(angle), POS_MIN, POS_MAX);
      end
      r.position = POS_W'(pos);
      r.turns = TURNS_W'(clip(turns_now, TURNS_MIN, TURNS_MAX));
      if (turns_now > turns_high)
         turns_high = int'(turns_now);
      if (turns_now < turns_low)
         turns_low = int'(turns_now);
   endtask

   always @(posedge clock) begin
      servo_reading_type want;
      if (reset) begin
         target = '0;
         kp = '0;
         ki = '0;
         kd = '0;
         running = 1'b0;
         foreach (window[i])
            window[i] = '0;
         angle = '0;
         turn_count = '0;
         error_sum = '0;
         last_error = '0;
         readings_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TARGET: target = csr_wdata[POS_W-1:0];
               CSR_GAIN_P: kp = csr_wdata[GAIN_W-1:0];
               CSR_GAIN_I: ki = csr_wdata[GAIN_W-1:0];
               CSR_GAIN_D: kd = csr_wdata[GAIN_W-1:0];
               CSR_RUN:    running = csr_wdata[0];
               default: ;  // drop writes to unmapped indexes
            endcase
         end

         if (req_valid && req_ready) begin
            servo_step(req_adc_sample, want);
            readings_q.push_back(want);
         end

         if (rsp_valid && rsp_ready) begin
            if (readings_q.size() == 0) begin
               $error("response with no request pending: pwm_level %0d position %0d turns %0d",
                      rsp_pwm_level, rsp_position, rsp_turns);
               mismatches++;
            end else begin
               want = readings_q.pop_front();
               readings_checked++;
               if (rsp_pwm_level !== want.level) begin
                  $error("pwm_level expected %0d, got %0d", want.level, rsp_pwm_level);
                  mismatches++;
               end
               if (rsp_position !== want.position) begin
                  $error("position expected %0d, got %0d", want.position, rsp_position);
                  mismatches++;
               end
               if (rsp_turns !== want.turns) begin
                  $error("turns expected %0d, got %0d", want.turns, rsp_turns);
                  mismatches++;
               end
            end
         end
         readings_due = readings_q.size();
      end
   end

endmodule

### test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mtsp_pkg::*;

   localparam int CYCLE_LIMIT      = 250000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES      = 20;
   localparam int SPIN_TURNS       = 136;

   localparam int TARGET_LOW  = -737280;
   localparam int TARGET_HIGH = 737279;
   localparam int GAIN_MAX    = (1 << GAIN_W) - 1;

   // pot readings that land clearly above, below and between the wrap thresholds
   localparam int HIGH_MIN = 3420;
   localparam int LOW_MAX  = 565;
   localparam int MID_MIN  = 600;
   localparam int MID_MAX  = 3400;

   localparam logic [SAMPLE_W-1:0] OPENING [13] = '{
      12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'h000,
      12'h800, 12'h800, 12'h800, 12'hAAA, 12'h555, 12'h001, 12'hFFE
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_W-1:0]       req_adc_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b1;
   logic [LEVEL_W-1:0]        rsp_pwm_level;
   logic signed [POS_W-1:0]   rsp_position;
   logic signed [TURNS_W-1:0] rsp_turns;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_TARGET;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   int mismatches, readings_due, readings_checked, turns_high, turns_low;
   int samples_sent = 0;
   int settings_loaded = 0;
   int cycle_count = 0;
   bit gaps_on = 1'b1;
   bit stalls_on = 1'b1;
   bit long_hold = 1'b0;
   bit hold_done = 1'b0;

   multiturn_servo_pid_with_median_top uut (.*);

   servo_loop_checker loop_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_adc_sample   (req_adc_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pwm_level    (rsp_pwm_level),
      .rsp_position     (rsp_position),
      .rsp_turns        (rsp_turns),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .readings_due     (readings_due),
      .readings_checked (readings_checked),
      .turns_high       (turns_high),
      .turns_low        (turns_low)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // response side back-pressure
   always begin
      @(posedge clock);
      if (long_hold && !hold_done) begin
         hold_done = 1'b1;
         rsp_ready <= 1'b0;
         repeat (LONG_HOLD_CYCLES) @(posedge clock);
         rsp_ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
         rsp_ready <= 1'b1;
      end
   end

   // valid stays high after the accept; callers lower it before any wait
   task automatic offer_sample(input logic [SAMPLE_W-1:0] s);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_adc_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (readings_due != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic load_settings(input int tgt, input int gp, input int gi, input int gd,
                                input bit run);
      logic [CSR_DATA_W-1:0] junk;
      req_valid <= 1'b0;
      wait_drained();
      junk = CSR_DATA_W'($urandom);
      write_csr(CSR_IDX_W'($urandom_range(int'(CSR_RUN) + 1, (1 << CSR_IDX_W) - 1)), junk);
      write_csr(CSR_TARGET, CSR_DATA_W'(tgt));
      // upper data bits are don't-care for the narrow registers
      junk = CSR_DATA_W'($urandom);
      junk[GAIN_W-1:0] = GAIN_W'(gp);
      write_csr(CSR_GAIN_P, junk);
      junk = CSR_DATA_W'($urandom);
      junk[GAIN_W-1:0] = GAIN_W'(gi);
      write_csr(CSR_GAIN_I, junk);
      junk = CSR_DATA_W'($urandom);
      junk[GAIN_W-1:0] = GAIN_W'(gd);
      write_csr(CSR_GAIN_D, junk);
      junk = CSR_DATA_W'($urandom);
      junk[0] = run;
      write_csr(CSR_RUN, junk);
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   function automatic int pick_target();
      return TARGET_LOW + int'($urandom_range(0, TARGET_HIGH - TARGET_LOW));
   endfunction

   function automatic int pick_gain();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, GAIN_MAX);
         1:       return $urandom_range(0, 600);
         default: return $urandom_range(0, 8);
      endcase
   endfunction

   // three readings per plateau so the median follows; mid plateau avoids a false unwind
   task automatic turn_over(input bit forward);
      for (int k = 0; k < 3; k++)
         offer_sample(SAMPLE_W'(forward ? $urandom_range(HIGH_MIN, 4095)
                                        : $urandom_range(0, LOW_MAX)));
      for (int k = 0; k < 3; k++)
         offer_sample(SAMPLE_W'(forward ? $urandom_range(0, LOW_MAX)
                                        : $urandom_range(HIGH_MIN, 4095)));
      offer_sample(SAMPLE_W'($urandom_range(MID_MIN, MID_MAX)));
   endtask

   task automatic mixed_bursts(input int count);
      int goal;
      int b;
      goal = samples_sent + count;
      while (samples_sent < goal) begin
         case ($urandom_range(0, 5))
            0, 1: turn_over(1'b1);
            2, 3: turn_over(1'b0);
            4: repeat ($urandom_range(1, 6)) offer_sample(SAMPLE_W'($urandom));
            default: begin
               b = $urandom_range(0, SAMPLE_W - 1);
               case ($urandom_range(0, 3))
                  0: offer_sample('0);
                  1: offer_sample('1);
                  2: offer_sample(SAMPLE_W'(1) << b);
                  default: offer_sample(~(SAMPLE_W'(1) << b));
               endcase
            end
         endcase
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      // loop halted out of reset: level zero and the window stays clear
      offer_sample('1);
      offer_sample('0);

      // filling window, wraps both ways, drive clamped high
      load_settings(TARGET_HIGH, GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b1);
      foreach (OPENING[i])
         offer_sample(OPENING[i]);

      // drive clamped low
      load_settings(TARGET_LOW, GAIN_MAX, 0, GAIN_MAX, 1'b1);
      repeat (3) offer_sample('1);
      repeat (3) offer_sample('0);
      offer_sample(12'h800);

      // spin forward until the turn count saturates; hold the response side midway
      load_settings(pick_target(), pick_gain(), pick_gain(), pick_gain(), 1'b1);
      for (int t = 0; t < SPIN_TURNS; t++) begin
         if (t == 20)
            long_hold = 1'b1;
         turn_over(1'b1);
      end

      load_settings(0, 0, 0, 0, 1'b1);
      mixed_bursts(70);

      load_settings(TARGET_LOW, GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b1);
      mixed_bursts(40);
      req_valid <= 1'b0;
      wait_drained();
      mixed_bursts(40);

      load_settings(pick_target(), pick_gain(), pick_gain(), pick_gain(), 1'b0);
      mixed_bursts(30);

      load_settings(TARGET_HIGH, pick_gain(), pick_gain(), pick_gain(), 1'b1);
      mixed_bursts(70);

      load_settings(pick_target(), pick_gain(), pick_gain(), pick_gain(), 1'b1);
      mixed_bursts(70);

      // closing stretch at full rate on both sides
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      load_settings(pick_target(), pick_gain(), pick_gain(), pick_gain(), 1'b1);
      mixed_bursts(100);

      req_valid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d pot samples across %0d loop settings; %0d responses compared.",
               samples_sent, settings_loaded, readings_checked);
      $display("Turn count ranged %0d to %0d, with halted loop, clamped drive and stalls.",
               turns_low, turns_high);
      if (mismatches == 0 && readings_due == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
